>>> rtl/bcpe_pkg.sv
// Shared types, widths and codes of the B-spline curve point evaluator.
package bcpe_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int MAX_DEGREE_DEF = 7;
	localparam int COORD_BITS     = 16;

	localparam int IDX_W   = 6;
	localparam int T_W     = 17;
	localparam int CNT_W   = 7;
	localparam int DEGC_W  = 3;
	localparam int BASIS_W = 31;
	localparam int TT_W    = 23;
	localparam int LR_W    = 23;
	localparam int DEN_W   = 24;
	localparam int PROD_W  = BASIS_W + LR_W;
	localparam int MULB_W  = 24;
	localparam int MULP_W  = BASIS_W + 1 + MULB_W;
	localparam int ACC_W   = BASIS_W + COORD_BITS + 4;
	localparam int FRAC_SH = 30;
	localparam int IW      = CNT_W + 2;

	localparam logic [T_W-1:0]     T_ONE   = T_W'(65536);
	localparam logic [BASIS_W-1:0] Q30_ONE = BASIS_W'(1) << FRAC_SH;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic REG_DEGREE = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef struct packed {
		logic                         op;
		logic [IDX_W-1:0]             point_index;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic [T_W-1:0]               param_t;
	} req_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] curve_x;
		logic signed [COORD_BITS-1:0] curve_y;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	typedef struct packed {
		logic               done;
		logic               rem_nz;
		logic [BASIS_W-1:0] quot;
	} div_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_SPAN,
		S_KNOT,
		S_MUL,
		S_DIVST,
		S_DIVW,
		S_UPD,
		S_ADDR,
		S_MULX,
		S_MULY,
		S_ADDY,
		S_FIN
	} state_t;

endpackage

>>> rtl/bcpe_store.sv
// Control point memory: one write port and one registered read port.
module bcpe_store #(
	parameter int DEPTH = bcpe_pkg::MAX_POINTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  bcpe_pkg::point_t wr_pt,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output bcpe_pkg::point_t rd_pt
);
	import bcpe_pkg::*;

	point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_pt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pt <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/bcpe_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module bcpe_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bcpe_pkg::PROD_W-1:0]       dividend,
	input  logic [bcpe_pkg::DEN_W-1:0]        divisor,
	output bcpe_pkg::div_stat_t               stat
);
	import bcpe_pkg::*;

	localparam int CW = $clog2(BASIS_W);

	logic                busy_q;
	logic [CW-1:0]       cnt_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DEN_W-1:0]    dvs_q;
	logic [BASIS_W-1:0]  shf_q;
	logic [DEN_W:0]      cand;
	logic [DEN_W:0]      diff;
	logic                fits;

	// The caller guarantees the quotient fits in BASIS_W bits, so the upper
	// dividend bits start out below the divisor.
	assign cand = {rem_q, shf_q[BASIS_W-1]};
	assign diff = cand - {1'b0, dvs_q};
	assign fits = (cand >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(BASIS_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(dividend[PROD_W-1:BASIS_W]);
			shf_q <= dividend[BASIS_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
			shf_q <= {shf_q[BASIS_W-2:0], fits};
		end
	end

	assign stat.done   = !busy_q;
	assign stat.rem_nz = (rem_q != '0);
	assign stat.quot   = shf_q;

endmodule

>>> rtl/bspline_curve_point_evaluator.sv
// Top level of the clamped uniform B-spline curve point evaluator.
// Usage: words arrive on the req channel (valid/ready). A word with op set to
// write stores one Q1.14 control point in the slot given by point_index;
// it produces no result. A word with op set to evaluate takes a Q1.16
// parameter t and yields one Q1.14 curve point on the rsp channel, rounded
// and saturated. The cfg channel writes spline_degree (index 0) and
// point_count (index 1); it is always ready and should only be used while
// the block is idle.
// Steps: after setup and the span lookup, each triangle update computes the
// distances, does one shared multiply, starts the divider, waits through the
// divider steps, one per quotient bit, until done, and writes back; over a
// zero-length knot interval it skips the divider. The weighted sum runs the
// address, x multiply, y multiply and y add states per control point. With
// too few points the sequencer goes straight to the finish state and delivers
// the zero result from there. req_ready is high only while the sequencer is
// idle, and returns at the edge that loads the result.
// Reset clears the sequencer, the output valid and restores degree 3 and a
// count of 4; the point memory is not cleared and must be written before use.
// A stalled receiver holds the result in the output register; the block can
// accept and finish the next word meanwhile, and only waits to deliver it.
module bspline_curve_point_evaluator #(
	parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF,
	parameter int MAX_DEGREE = bcpe_pkg::MAX_DEGREE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bcpe_pkg::req_t             req_data,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output bcpe_pkg::rsp_t             rsp_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [bcpe_pkg::CNT_W-1:0] cfg_data
);
	import bcpe_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NB = $clog2(MAX_DEGREE + 1);

	// Knot i of the clamped uniform vector, scaled by 65536.
	function automatic logic [LR_W-1:0] knot(input logic signed [IW-1:0] i,
			input logic [NB-1:0] p, input logic [CNT_W-1:0] d);
		logic signed [IW-1:0] v;
		v = i - $signed(IW'(p));
		if (v < 0) begin
			v = '0;
		end else if (v > $signed(IW'(d))) begin
			v = $signed(IW'(d));
		end
		return {v[CNT_W-1:0], 16'b0};
	endfunction

	// Round a Q.44 sum to Q1.14 and saturate.
	function automatic logic signed [COORD_BITS-1:0] round_sat(
			input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0]        sum;
		logic signed [ACC_W-FRAC_SH-1:0] q;
		logic signed [ACC_W-FRAC_SH-1:0] hi;
		logic signed [ACC_W-FRAC_SH-1:0] lo;
		sum = acc + (ACC_W'(1) << (FRAC_SH - 1));
		q   = sum[ACC_W-1:FRAC_SH];
		hi  = (ACC_W-FRAC_SH)'((1 << (COORD_BITS - 1)) - 1);
		lo  = -hi - 1'b1;
		if (q > hi) begin
			q = hi;
		end else if (q < lo) begin
			q = lo;
		end
		return q[COORD_BITS-1:0];
	endfunction

	state_t state_q, state_d;

	logic [DEGC_W-1:0] deg_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [NB-1:0]             p_q, j_q, r_q;
	logic [CNT_W-1:0]          d_q;
	logic [T_W-1:0]            t_q;
	logic [TT_W-1:0]           tt_q;
	logic signed [IW-1:0]      s_q;
	logic [BASIS_W-1:0]        basis_q [MAX_DEGREE+1];
	logic [BASIS_W-1:0]        saved_q;
	logic [LR_W-1:0]           rv_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [MULP_W-1:0]  mul_q;
	logic signed [ACC_W-1:0]   accx_q, accy_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	logic                      req_acc;
	logic [NB-1:0]             p_cfg;
	logic [CNT_W-1:0]          n_cfg;
	logic                      too_few;

	logic [NB-1:0]             b_idx;
	logic [BASIS_W-1:0]        b_rd;
	logic signed [MULB_W-1:0]  mul_b;
	logic [BASIS_W-1:0]        mul_a;
	logic                      div_start;
	div_stat_t                 div_st;

	logic [CNT_W-1:0]          seg_raw, seg;
	logic signed [TT_W:0]      rv_raw, lv_raw;
	logic [LR_W-1:0]           rv, lv;
	logic                      last_r;
	logic [BASIS_W-1:0]        upd_a, upd_b;
	logic                      out_free;

	logic                      wr_en, rd_en;
	logic [AW-1:0]             rd_addr;
	point_t                    rd_pt, wr_pt;

	assign cfg_ready = 1'b1;
	assign req_acc   = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= DEGC_W'(3);
			cnt_q <= CNT_W'(4);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEGREE: deg_q <= cfg_data[DEGC_W-1:0];
				REG_COUNT:  cnt_q <= cfg_data;
				default:    deg_q <= deg_q;
			endcase
		end
	end

	// Degree and count limited to what the hardware holds.
	assign p_cfg   = (32'(deg_q) > MAX_DEGREE) ? NB'(MAX_DEGREE) : NB'(deg_q);
	assign n_cfg   = (32'(cnt_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : cnt_q;
	assign too_few = (32'(n_cfg) < 32'(p_cfg) + 1);

	// Span index from the scaled parameter, kept inside the last span.
	assign seg_raw = mul_q[TT_W-1:16];
	assign seg     = (seg_raw > d_q - 1'b1) ? d_q - 1'b1 : seg_raw;

	// Right and left distances of the current triangle update.
	assign rv_raw = $signed({1'b0, knot(s_q + $signed(IW'(r_q)) + 1'b1, p_q, d_q)})
		- $signed({1'b0, tt_q});
	assign lv_raw = $signed({1'b0, tt_q})
		- $signed({1'b0, knot(s_q + 1'b1 - $signed(IW'(j_q)) + $signed(IW'(r_q)),
		p_q, d_q)});
	assign rv = rv_raw[TT_W] ? '0 : rv_raw[LR_W-1:0];
	assign lv = lv_raw[TT_W] ? '0 : lv_raw[LR_W-1:0];

	assign b_rd   = basis_q[b_idx];
	assign last_r = ({1'b0, r_q} + 1'b1 == {1'b0, j_q});

	// The two quotients share one division: the left weight is the rest of
	// the basis value, less one when the right quotient was inexact.
	assign upd_a = (den_q == '0) ? '0 : div_st.quot;
	assign upd_b = (den_q == '0) ? '0 : b_rd - div_st.quot - BASIS_W'(div_st.rem_nz);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && req_data.op == OP_EVAL) begin
					state_d = too_few ? S_FIN : S_SETUP;
				end
			end
			S_SETUP: state_d = S_SPAN;
			S_SPAN:  state_d = (p_q == '0) ? S_ADDR : S_KNOT;
			S_KNOT:  state_d = S_MUL;
			S_MUL:   state_d = (den_q == '0) ? S_UPD : S_DIVST;
			S_DIVST: state_d = S_DIVW;
			S_DIVW: begin
				if (div_st.done) begin
					state_d = S_UPD;
				end
			end
			S_UPD:   state_d = (last_r && j_q == p_q) ? S_ADDR : S_KNOT;
			S_ADDR:  state_d = S_MULX;
			S_MULX:  state_d = S_MULY;
			S_MULY:  state_d = S_ADDY;
			S_ADDY:  state_d = (j_q == p_q) ? S_FIN : S_ADDR;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		div_start = 1'b0;
		rd_en     = 1'b0;
		b_idx     = r_q;
		mul_a     = b_rd;
		mul_b     = $signed({1'b0, rv_q});
		unique case (state_q)
			S_IDLE:  req_ready = 1'b1;
			S_SETUP: begin
				mul_a = BASIS_W'(t_q);
				mul_b = $signed(MULB_W'(d_q));
			end
			S_DIVST: div_start = 1'b1;
			S_ADDR:  rd_en = 1'b1;
			S_MULX: begin
				b_idx = j_q;
				mul_b = MULB_W'(rd_pt.x);
			end
			S_MULY: begin
				b_idx = j_q;
				mul_b = MULB_W'(rd_pt.y);
			end
			default: b_idx = r_q;
		endcase
	end

	assign rd_addr = AW'(s_q - $signed(IW'(p_q)) + $signed(IW'(j_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= $signed({1'b0, mul_a}) * mul_b;
		unique case (state_q)
			S_IDLE: begin
				p_q    <= p_cfg;
				d_q    <= n_cfg - CNT_W'(p_cfg);
				t_q    <= (req_data.param_t > T_ONE) ? T_ONE : req_data.param_t;
				accx_q <= '0;
				accy_q <= '0;
			end
			S_SPAN: begin
				tt_q       <= mul_q[TT_W-1:0];
				s_q        <= $signed(IW'(p_q)) + $signed(IW'(seg));
				basis_q[0] <= Q30_ONE;
				saved_q    <= '0;
				r_q        <= '0;
				j_q        <= (p_q == '0) ? '0 : NB'(1);
			end
			S_KNOT: begin
				rv_q  <= rv;
				den_q <= DEN_W'(rv) + DEN_W'(lv);
			end
			S_UPD: begin
				basis_q[r_q] <= saved_q + upd_a;
				if (last_r) begin
					basis_q[j_q] <= upd_b;
					saved_q      <= '0;
					r_q          <= '0;
					j_q          <= (j_q == p_q) ? '0 : j_q + 1'b1;
				end else begin
					saved_q <= upd_b;
					r_q     <= r_q + 1'b1;
				end
			end
			S_MULY: accx_q <= accx_q + ACC_W'(mul_q);
			S_ADDY: begin
				accy_q <= accy_q + ACC_W'(mul_q);
				if (j_q != p_q) begin
					j_q <= j_q + 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					rsp_q.curve_x <= round_sat(accx_q);
					rsp_q.curve_y <= round_sat(accy_q);
				end
			end
			default: tt_q <= tt_q;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign wr_en   = req_acc && req_data.op == OP_WRITE
		&& (32'(req_data.point_index) < MAX_POINTS);
	assign wr_pt.x = req_data.point_x;
	assign wr_pt.y = req_data.point_y;

	bcpe_store #(
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(req_data.point_index)),
		.wr_pt  (wr_pt),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_pt  (rd_pt)
	);

	bcpe_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mul_q[PROD_W-1:0]),
		.divisor (den_q),
		.stat    (div_st)
	);

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the clamped uniform B-spline curve point evaluator.
`timescale 1ns / 100ps

module tb_top;
	import bcpe_pkg::*;

	// Run length and pacing.
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 118;
	localparam int DIR_ROWS    = 31;
	localparam int HOLD_CYCLES = 2500;
	localparam int SETTLE_WAIT = 8;
	localparam int END_WAIT    = 1100;
	localparam int SLOTS       = MAX_POINTS_DEF;

	localparam longint unsigned BASIS_ONE = 64'd1 << 30;

	// A directed row either sends one request word or writes one register.
	typedef enum logic [0:0] {
		ROW_WORD,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		req_t                word;
		logic                sel;
		logic [CNT_W-1:0]    val;
		logic                typed;
		rsp_t                want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req_data = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = REG_DEGREE;
	logic [CNT_W-1:0] cfg_data = '0;

	bspline_curve_point_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our own copy of the block's state: the control point table, which slots
	// have been written so far, and the two configuration registers.
	point_t           pts [SLOTS];
	bit               written [SLOTS];
	logic [2:0]       deg_now;
	logic [CNT_W-1:0] count_now;

	// Curve points still owed by the block, oldest first.
	rsp_t curve_due [$];

	dir_row_t dir_tab [DIR_ROWS];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asks      = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int err_cnt        = 0;
	int n_writes       = 0;
	int n_evals        = 0;
	int n_results      = 0;
	int cycle_cnt      = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Knot i of the clamped uniform vector, scaled by D = count - degree and by 65536.
	function automatic longint knot_at(int i, int p, int d);
		int v;
		v = i - p;
		if (v < 0) v = 0;
		if (v > d) v = d;
		return longint'(v) * 65536;
	endfunction

	// Round a Q.44 weighted sum to Q1.14 (half up) and clip to 16 bits.
	function automatic logic signed [COORD_BITS-1:0] round_clip(longint acc);
		longint q;
		q = (acc + (longint'(1) <<< 29)) >>> 30;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[COORD_BITS-1:0];
	endfunction

	// Curve point at parameter t under the current degree and point count.
	// Basis values are Q1.30 and every triangle update floors exactly, as the
	// hardware's divider does.
	function automatic rsp_t eval_curve(logic [T_W-1:0] t_in);
		int               p, n, d, s, j, r, idx;
		longint           tt, seg, den, accx, accy;
		longint           lft [8];
		longint           rgt [8];
		longint unsigned  bas [8];
		longint unsigned  carry, wa, wb;
		logic [T_W-1:0]   t_sat;
		rsp_t             res;
		res = '0;
		p = int'(deg_now);
		n = (int'(count_now) > SLOTS) ? SLOTS : int'(count_now);
		// Too few points for the degree gives the origin.
		if (n < p + 1) return res;
		d = n - p;
		t_sat = (t_in > T_ONE) ? T_ONE : t_in;
		tt = longint'(t_sat) * d;
		seg = tt / 65536;
		// t = 1.0 belongs to the last span, not one past it.
		if (seg > d - 1) seg = d - 1;
		s = p + int'(seg);
		bas[0] = BASIS_ONE;
		for (j = 1; j <= p; j++) begin
			carry = 0;
			lft[j] = tt - knot_at(s + 1 - j, p, d);
			rgt[j] = knot_at(s + j, p, d) - tt;
			if (lft[j] < 0) lft[j] = 0;
			if (rgt[j] < 0) rgt[j] = 0;
			for (r = 0; r < j; r++) begin
				den = rgt[r + 1] + lft[j - r];
				wa = 0;
				wb = 0;
				// A zero-length knot interval contributes nothing.
				if (den > 0) begin
					wa = bas[r] * longint'(rgt[r + 1]) / longint'(den);
					wb = bas[r] * longint'(lft[j - r]) / longint'(den);
				end
				bas[r] = carry + wa;
				carry = wb;
			end
			bas[j] = carry;
		end
		accx = 0;
		accy = 0;
		for (j = 0; j <= p; j++) begin
			idx = s - p + j;
			accx += longint'(bas[j]) * longint'(signed'(pts[idx].x));
			accy += longint'(bas[j]) * longint'(signed'(pts[idx].y));
		end
		res.curve_x = round_clip(accx);
		res.curve_y = round_clip(accy);
		return res;
	endfunction

	// Apply one accepted word to our copy of the state, and queue the curve
	// point it owes. A typed row brings its own expected point.
	task automatic take_word(req_t w, logic typed, rsp_t want);
		rsp_t due;
		if (w.op == OP_WRITE) begin
			pts[w.point_index].x = w.point_x;
			pts[w.point_index].y = w.point_y;
			written[w.point_index] = 1'b1;
			n_writes++;
		end else begin
			due = typed ? want : eval_curve(w.param_t);
			curve_due = {curve_due, due};
			n_evals++;
		end
	endtask

	// ------------------------------------------------------------------
	// Directed table rows
	// ------------------------------------------------------------------

	function automatic dir_row_t row_write(int slot, int x, int y);
		dir_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.word.op = OP_WRITE;
		r.word.point_index = IDX_W'(slot);
		r.word.point_x = COORD_BITS'(x);
		r.word.point_y = COORD_BITS'(y);
		return r;
	endfunction

	function automatic dir_row_t row_eval(int t);
		dir_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.word.op = OP_EVAL;
		r.word.param_t = T_W'(t);
		return r;
	endfunction

	// Evaluation whose answer is obvious: an end point, a constant span or
	// the origin.
	function automatic dir_row_t row_eval_is(int t, int x, int y);
		dir_row_t r;
		r = row_eval(t);
		r.typed = 1'b1;
		r.want.curve_x = COORD_BITS'(x);
		r.want.curve_y = COORD_BITS'(y);
		return r;
	endfunction

	function automatic dir_row_t row_cfg(logic sel, int val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.sel = sel;
		r.val = CNT_W'(val);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Coordinates lean on the two extremes now and then.
	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	// A random word. Fields the operation does not use are random too, so
	// that every bit of the payload toggles. Parameters favor the knots of
	// the current configuration, the two ends, and values above one.
	function automatic req_t random_word();
		req_t w;
		int   n, d, k, tk, pick;
		w.op = ($urandom_range(0, 99) < 60) ? OP_EVAL : OP_WRITE;
		w.point_index = IDX_W'($urandom_range(0, SLOTS - 1));
		w.point_x = rand_coord();
		w.point_y = rand_coord();
		n = (int'(count_now) > SLOTS) ? SLOTS : int'(count_now);
		d = n - int'(deg_now);
		pick = $urandom_range(0, 19);
		if (pick < 3) begin
			w.param_t = T_W'($urandom);
		end else if (pick < 4) begin
			w.param_t = ($urandom_range(0, 1) == 1) ? T_ONE : '0;
		end else if (pick < 8 && d > 0) begin
			k = $urandom_range(0, d);
			tk = (k * 65536) / d + $urandom_range(0, 2) - 1;
			if (tk < 0) tk = 0;
			if (tk > 65536) tk = 65536;
			w.param_t = T_W'(tk);
		end else begin
			w.param_t = T_W'($urandom_range(0, 65536));
		end
		return w;
	endfunction

	// Offer one word, holding valid and payload steady until the block takes
	// it. Called and returning at a falling edge; valid is left high so that
	// a back-to-back word follows without a gap.
	task automatic send_word(req_t w, logic typed, rsp_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_data = w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		take_word(w, typed, want);
		@(negedge clk);
	endtask

	// Write one configuration register through its own channel.
	task automatic write_reg(logic sel, logic [CNT_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = sel;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (sel == REG_DEGREE) deg_now = val[2:0];
		else count_now = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stop offering words, wait for every owed curve point, then let a
	// trailing control point write finish.
	task automatic settle_block();
		req_valid = 1'b0;
		while (curve_due.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	// The point table has no reset value, so every slot an evaluation can
	// touch under the current count is written before any evaluation runs.
	task automatic fill_used_slots();
		int   n, i;
		req_t w;
		n = (int'(count_now) > SLOTS) ? SLOTS : int'(count_now);
		for (i = 0; i < n; i++) begin
			if (!written[i]) begin
				w = random_word();
				w.op = OP_WRITE;
				w.point_index = IDX_W'(i);
				send_word(w, 1'b0, '0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	task automatic report_mismatch(string msg);
		err_cnt++;
		$display("ERROR: %s", msg);
	endtask

	// Output ready is decided at each falling edge. A hold request from the
	// main sequence forces a long stretch of back-pressure, so the block
	// fills its output register, finishes the next word and then refuses
	// new input while the sender keeps offering.
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			rsp_ready = 1'b0;
			hold_left--;
		end else begin
			rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Every accepted curve point is compared with the oldest one owed.
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_results++;
			if (curve_due.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none owed: x %0d y %0d",
					n_results, rsp_data.curve_x, rsp_data.curve_y));
			end else begin
				want = curve_due.pop_front();
				if (rsp_data.curve_x !== want.curve_x)
					report_mismatch($sformatf("result %0d curve_x: got %0d, want %0d",
						n_results, rsp_data.curve_x, want.curve_x));
				if (rsp_data.curve_y !== want.curve_y)
					report_mismatch($sformatf("result %0d curve_y: got %0d, want %0d",
						n_results, rsp_data.curve_y, want.curve_y));
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("ERROR: timeout after %0d cycles, %0d results still owed",
			cycle_cnt, curve_due.size());
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin : main_seq
		int               i, ph, deg_sel, cnt_sel;
		int               phase_deg [PHASES];
		int               phase_cnt [PHASES];

		// Degree and count per phase: both register extremes, count above the
		// table, too few points for the degree, a single span, the full table.
		// The last phase picks its setting at random.
		phase_deg = '{1, 7, 0, 2, 5, 3, 4, 7, 6, 2, 1, 0};
		phase_cnt = '{2, 64, 5, 127, 3, 10, 33, 8, 20, 0, 100, 0};

		// Directed part. After reset the block runs a cubic over four points.
		// The end points come back exactly at t = 0 and t = 1, parameters
		// above one clip to one, a piecewise-constant curve returns the point
		// of its span, and too few points give the origin.
		dir_tab = '{
			row_write(0, -32768, 32767),
			row_write(1, 16384, -16384),
			row_write(2, 0, 4660),
			row_write(3, 32767, -32768),
			row_write(4, 12000, -12000),
			row_write(5, -20000, 5000),
			row_write(6, 3, -3),
			row_write(7, 8192, -8192),
			row_eval_is(0, -32768, 32767),
			row_eval_is(65536, 32767, -32768),
			row_eval_is(131071, 32767, -32768),
			row_eval_is(65537, 32767, -32768),
			row_eval(32768),
			row_eval(65535),
			row_eval(1),
			row_cfg(REG_COUNT, 2),
			row_eval_is(12345, 0, 0),
			row_cfg(REG_DEGREE, 0),
			row_cfg(REG_COUNT, 4),
			row_eval_is(0, -32768, 32767),
			row_eval_is(16384, 16384, -16384),
			row_eval_is(65536, 32767, -32768),
			row_eval(40000),
			row_cfg(REG_DEGREE, 7),
			row_cfg(REG_COUNT, 8),
			row_eval_is(65536, 8192, -8192),
			row_eval_is(0, -32768, 32767),
			row_eval(32768),
			row_cfg(REG_COUNT, 0),
			row_eval_is(50000, 0, 0),
			row_write(63, -32768, -32768)
		};

		// Reset values of our copy match the block's registers.
		deg_now = 3'd3;
		count_now = CNT_W'(4);
		for (i = 0; i < SLOTS; i++) begin
			written[i] = 1'b0;
			pts[i] = '0;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				settle_block();
				write_reg(dir_tab[i].sel, dir_tab[i].val);
			end else begin
				send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		// Random part. The phases rotate through four handshake mixes: free
		// flow, a sparse sender, a stalling receiver, and light idling on
		// both sides. The first phase also carries the long output hold.
		for (ph = 0; ph < PHASES; ph++) begin
			settle_block();
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 78;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 78;
				end
				default: begin
					send_idle_pct = 24;
					recv_stall_pct = 24;
				end
			endcase
			deg_sel = (ph == PHASES - 1) ? $urandom_range(0, 7) : phase_deg[ph];
			cnt_sel = (ph == PHASES - 1) ? $urandom_range(0, 127) : phase_cnt[ph];
			write_reg(REG_DEGREE, CNT_W'(deg_sel));
			write_reg(REG_COUNT, CNT_W'(cnt_sel));
			if (ph == 0) hold_asks++;
			fill_used_slots();
			repeat (PHASE_ITEMS) send_word(random_word(), 1'b0, '0);
		end

		// Drain, then leave room for anything the block might still send.
		settle_block();
		repeat (END_WAIT) @(posedge clk);

		$display("Run covered %0d control point writes and %0d curve evaluations, %0d checked,",
			n_writes, n_evals, n_results);
		$display("over %0d degree/count settings and four handshake mixes in %0d cycles.",
			PHASES + 4, cycle_cnt);
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches found", err_cnt);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
